/* design/tbwd_pkg.sv */
// ----------------------------------------------------------------------------
// tbwd_pkg
// Types and constants shared by the time budget watchdog check block.
// ----------------------------------------------------------------------------
package tbwd_pkg;

  localparam logic [31:0] MAX_BUDGET_MS    = 32'd3600000;
  localparam logic [31:0] MS_TO_TICK_UNITS = 32'd10000;
  localparam logic [31:0] PERCENT_FULL     = 32'd100;

  localparam logic [19:0] TIME_INCREMENT_RESET = 20'd156250;
  localparam logic [4:0]  RUN_LEVEL_RESET      = 5'd2;

  localparam logic [2:0] CFG_MAX_TIME_MS        = 3'd0;
  localparam logic [2:0] CFG_TIME_INCREMENT     = 3'd1;
  localparam logic [2:0] CFG_TRY_EXTEND         = 3'd2;
  localparam logic [2:0] CFG_STARVATION_PERCENT = 3'd3;
  localparam logic [2:0] CFG_RUN_LEVEL          = 3'd4;

  localparam logic [2:0] REASON_NONE    = 3'd0;
  localparam logic [2:0] REASON_ELAPSED = 3'd1;
  localparam logic [2:0] REASON_YIELD   = 3'd2;
  localparam logic [2:0] REASON_SINGLE  = 3'd3;
  localparam logic [2:0] REASON_TOTAL   = 3'd4;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [62:0] current_tick;
    logic        yield_hint;
    logic        watchdog_ok;
    logic [31:0] single_limit;
    logic [31:0] single_remaining;
    logic [31:0] total_limit;
    logic [31:0] total_remaining;
  } in_item_t;

  typedef struct packed {
    logic        out_of_budget;
    logic [2:0]  last_reason;
    logic [31:0] time_spent;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_COMMIT,
    S_QUERY,
    S_WD_S,
    S_WD_SC,
    S_WD_T,
    S_WD_TC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic       load_item;
    logic       mul_units;
    logic       mul_single;
    logic       mul_total;
    logic       div_step;
    logic       commit_start;
    logic       spent_we;
    logic       reason_we;
    logic [2:0] reason;
    logic       stop_we;
    logic       stop;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_kind;
    logic passive;
    logic budget_zero;
    logic past_end;
    logic try_extend;
    logic yield_hint;
    logic wd_ok;
    logic div_last;
    logic single_hit;
    logic total_hit;
    logic out_free;
  } dp_status_t;

endpackage

/* design/tbwd_datapath.sv */
// ----------------------------------------------------------------------------
// tbwd_datapath
// Configuration registers, budget state, shared multiplier, radix-2 divider
// and output register of the time budget watchdog check block.
// ----------------------------------------------------------------------------
module tbwd_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbwd_pkg::in_item_t  in_data_i,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  tbwd_pkg::ctrl_cmd_t cmd_i,
  output tbwd_pkg::dp_status_t status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output tbwd_pkg::out_item_t out_data_o
);
  import tbwd_pkg::*;

  in_item_t    item_q;
  logic [31:0] max_ms_q;
  logic [19:0] tinc_q;
  logic        try_ext_q;
  logic [6:0]  starv_q;
  logic [4:0]  run_level_q;

  logic [62:0] start_tick_q;
  logic [63:0] end_tick_q;
  logic [31:0] budget_q;
  logic [31:0] spent_q;
  logic [2:0]  reason_q;
  logic        stop_q;

  logic [31:0] prod_q, prod_d;
  logic [19:0] rem_q, rem_d;
  logic [31:0] quot_q;
  logic [4:0]  cnt_q;
  logic        qbit;

  logic        out_valid_q;
  out_item_t   out_q;

  logic [31:0] ms_clamp;
  logic [31:0] allowed;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_full;
  logic [20:0] trial;
  logic [20:0] div_ext;
  logic [4:0]  bit_idx;
  logic [31:0] budget_d;
  logic [31:0] pct_s, pct_t;
  logic        spent_ok;

  assign ms_clamp = (max_ms_q < MAX_BUDGET_MS) ? max_ms_q : MAX_BUDGET_MS;
  assign allowed  = PERCENT_FULL - {25'd0, starv_q};

  always_comb begin
    mul_a = ms_clamp;
    mul_b = MS_TO_TICK_UNITS;
    if (cmd_i.mul_single) begin
      mul_a = item_q.single_limit;
      mul_b = allowed;
    end else if (cmd_i.mul_total) begin
      mul_a = item_q.total_limit;
      mul_b = allowed;
    end
  end

  assign mul_full = mul_a * mul_b;
  assign prod_d   = mul_full[31:0];

  // restoring division of prod_q by the tick increment, msb first
  assign bit_idx = 5'd31 - cnt_q;
  assign trial   = {rem_q, prod_q[bit_idx]};
  assign div_ext = {1'b0, tinc_q};

  always_comb begin
    if (trial >= div_ext) begin
      qbit  = 1'b1;
      rem_d = 20'(trial - div_ext);
    end else begin
      qbit  = 1'b0;
      rem_d = trial[19:0];
    end
  end

  assign budget_d = (tinc_q == 20'd0) ? 32'd0 : quot_q;

  // times 100 as shift and add, wrapping to 32 bits
  assign pct_s = (item_q.single_remaining << 6) + (item_q.single_remaining << 5)
               + (item_q.single_remaining << 2);
  assign pct_t = (item_q.total_remaining << 6) + (item_q.total_remaining << 5)
               + (item_q.total_remaining << 2);

  assign spent_ok = (item_q.current_tick > start_tick_q) && (start_tick_q != 63'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ms_q    <= 32'd0;
      tinc_q      <= TIME_INCREMENT_RESET;
      try_ext_q   <= 1'b0;
      starv_q     <= 7'd0;
      run_level_q <= RUN_LEVEL_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_TIME_MS:        max_ms_q    <= cfg_data_i;
        CFG_TIME_INCREMENT:     tinc_q      <= cfg_data_i[19:0];
        CFG_TRY_EXTEND:         try_ext_q   <= cfg_data_i[0];
        CFG_STARVATION_PERCENT: starv_q     <= cfg_data_i[6:0];
        CFG_RUN_LEVEL:          run_level_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_tick_q <= 63'd0;
      end_tick_q   <= 64'd0;
      budget_q     <= 32'd0;
      spent_q      <= 32'd0;
      reason_q     <= REASON_NONE;
      stop_q       <= 1'b0;
    end else begin
      if (cmd_i.commit_start) begin
        budget_q     <= budget_d;
        start_tick_q <= item_q.current_tick;
        end_tick_q   <= {1'b0, item_q.current_tick} + {32'd0, budget_d};
        stop_q       <= 1'b0;
      end
      if (cmd_i.spent_we && spent_ok) begin
        spent_q <= item_q.current_tick[31:0] - start_tick_q[31:0];
      end
      if (cmd_i.reason_we) begin
        reason_q <= cmd_i.reason;
      end
      if (cmd_i.stop_we) begin
        stop_q <= cmd_i.stop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.mul_units || cmd_i.mul_single || cmd_i.mul_total) begin
      prod_q <= prod_d;
    end
    if (cmd_i.div_step) begin
      quot_q <= {quot_q[30:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 20'd0;
      cnt_q <= 5'd0;
    end else if (cmd_i.mul_units) begin
      rem_q <= 20'd0;
      cnt_q <= 5'd0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      cnt_q <= cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_of_budget <= stop_q;
      out_q.last_reason   <= reason_q;
      out_q.time_spent    <= spent_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.in_kind     = in_data_i.kind;
  assign status_o.passive     = (run_level_q == 5'd0);
  assign status_o.budget_zero = (budget_q == 32'd0);
  assign status_o.past_end    = ({1'b0, item_q.current_tick} > end_tick_q);
  assign status_o.try_extend  = try_ext_q;
  assign status_o.yield_hint  = item_q.yield_hint;
  assign status_o.wd_ok       = item_q.watchdog_ok;
  assign status_o.div_last    = (cnt_q == 5'd31);
  assign status_o.single_hit  = (item_q.single_limit != 32'd0) && (pct_s < prod_q);
  assign status_o.total_hit   = (item_q.total_limit != 32'd0) && (pct_t < prod_q);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

endmodule

/* design/tbwd_controller.sv */
// ----------------------------------------------------------------------------
// tbwd_controller
// Sequencer for start and query requests of the time budget watchdog check.
// ----------------------------------------------------------------------------
module tbwd_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tbwd_pkg::dp_status_t status_i,
  output tbwd_pkg::ctrl_cmd_t  cmd_o
);
  import tbwd_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (status_i.in_kind == KIND_QUERY) ? S_QUERY : S_MUL;
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (status_i.div_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: state_d = S_OUT;
      S_QUERY: begin
        if (status_i.passive || status_i.budget_zero || status_i.past_end ||
            !status_i.wd_ok) begin
          state_d = S_OUT;
        end else begin
          state_d = S_WD_S;
        end
      end
      S_WD_S: state_d = S_WD_SC;
      S_WD_SC: state_d = status_i.single_hit ? S_OUT : S_WD_T;
      S_WD_T: state_d = S_WD_TC;
      S_WD_TC: state_d = S_OUT;
      S_OUT: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.reason    = REASON_NONE;
    cmd_o.load_item = accept;
    case (state_q)
      S_MUL:    cmd_o.mul_units    = 1'b1;
      S_DIV:    cmd_o.div_step     = 1'b1;
      S_COMMIT: cmd_o.commit_start = 1'b1;
      S_QUERY: begin
        cmd_o.stop_we = 1'b1;
        if (status_i.passive) begin
          cmd_o.stop = 1'b0;
        end else if (status_i.budget_zero) begin
          cmd_o.stop      = status_i.yield_hint;
          cmd_o.reason_we = status_i.yield_hint;
          cmd_o.reason    = REASON_YIELD;
        end else begin
          cmd_o.spent_we = 1'b1;
          if (status_i.past_end) begin
            if (status_i.try_extend) begin
              cmd_o.stop      = status_i.yield_hint;
              cmd_o.reason_we = status_i.yield_hint;
              cmd_o.reason    = REASON_YIELD;
            end else begin
              cmd_o.stop      = 1'b1;
              cmd_o.reason_we = 1'b1;
              cmd_o.reason    = REASON_ELAPSED;
            end
          end else begin
            cmd_o.stop = 1'b0;
          end
        end
      end
      S_WD_S: cmd_o.mul_single = 1'b1;
      S_WD_SC: begin
        cmd_o.stop_we   = status_i.single_hit;
        cmd_o.stop      = 1'b1;
        cmd_o.reason_we = status_i.single_hit;
        cmd_o.reason    = REASON_SINGLE;
      end
      S_WD_T: cmd_o.mul_total = 1'b1;
      S_WD_TC: begin
        cmd_o.stop_we   = 1'b1;
        cmd_o.stop      = status_i.total_hit;
        cmd_o.reason_we = status_i.total_hit;
        cmd_o.reason    = REASON_TOTAL;
      end
      S_OUT: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

/* design/time_budget_watchdog_check.sv */
// ----------------------------------------------------------------------------
// time_budget_watchdog_check
// Processing-time budget checker with watchdog threshold tests.
// ----------------------------------------------------------------------------
// start request: the budget comes from the radix-2 budget divider, one quotient
//   bit per cycle; the next request is taken once the result is loaded
// query request: up to two watchdog products from the shared multiplier, single
//   then total, each formed in one state and compared in the next
// reset: asynchronous, clears budget state and output valid, loads register
//   reset values; no clearing pass
module time_budget_watchdog_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tbwd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tbwd_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import tbwd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  tbwd_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tbwd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready while a request is in flight");

  a_reason_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.last_reason <= REASON_TOTAL)
    else $error("reason code out of range");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result issued without a request in flight");

endmodule
